// File: rtl/olst_pkg.sv
// Shared types, codes and sizes for the ordered array list.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package olst_pkg;

  localparam int CAPACITY = 8;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 4;
  localparam int POS_W    = 4;
  localparam int VAL_W    = 32;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 3;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
  } mem_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  found_position;
    logic [VAL_W-1:0]  read_value;
    logic [CNT_W-1:0]  item_count;
  } result_t;

endpackage

// File: rtl/olst_store.sv
// Entry store: one write port and one registered read port.
// Depends on olst_pkg.
`timescale 1ns / 1ps

module olst_store (
  input  logic                            clk,
  input  olst_pkg::mem_req_t              req,
  output logic [olst_pkg::VAL_W-1:0]      rdata
);
  import olst_pkg::*;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/olst_seq.sv
// Command sequencer: range checks, shift loop over the store, scan with the
// equality compare, and result assembly. Depends on olst_pkg.
`timescale 1ns / 1ps

module olst_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [olst_pkg::CMD_W-1:0]    in_cmd,
  input  logic [olst_pkg::POS_W-1:0]    in_position,
  input  logic [olst_pkg::VAL_W-1:0]    in_value,
  output olst_pkg::mem_req_t            mem_req,
  input  logic [olst_pkg::VAL_W-1:0]    mem_rdata,
  output logic                          res_valid,
  input  logic                          res_ready,
  output olst_pkg::result_t             res
);
  import olst_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_PUT   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_GRAB  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [ADDR_W-1:0] ins_addr_r, ins_addr_nxt;
  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [CNT_W-1:0]  found_r, found_nxt;
  logic [VAL_W-1:0]  rdv_r, rdv_nxt;

  logic [CNT_W:0] cnt_x, pos_x, cnt_p1;
  logic           pos_ok_ins, pos_ok, empty, full, hit;

  assign cnt_x      = {1'b0, count_r};
  assign pos_x      = {1'b0, in_position};
  assign cnt_p1     = cnt_x + (CNT_W+1)'(1);
  assign pos_ok_ins = (in_position != '0) && (pos_x <= cnt_p1);
  assign pos_ok     = (in_position != '0) && (pos_x <= cnt_x);
  assign empty      = (count_r == '0);
  assign full       = (count_r >= CNT_W'(CAPACITY));
  // the one comparator: scan match
  assign hit        = pend_r && (mem_rdata == val_r);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = '{status: status_r, found_position: found_r,
                       read_value: rdv_r, item_count: count_r};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    ins_addr_nxt  = ins_addr_r;
    rd_addr_nxt   = rd_addr_r;
    left_nxt      = left_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    rdv_nxt       = rdv_r;
    mem_req       = '{re: 1'b0, raddr: rd_addr_r, we: 1'b0, waddr: '0, wdata: mem_rdata};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_cmd;
          val_nxt      = in_value;
          ins_addr_nxt = ADDR_W'(in_position - POS_W'(1));
          status_nxt   = ST_OK;
          found_nxt    = '0;
          rdv_nxt      = '0;
          state_nxt    = S_DONE;
          case (in_cmd)
            CMD_INSERT: begin
              if (!pos_ok_ins) begin
                status_nxt = ST_BADPOS;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                rd_addr_nxt = ADDR_W'(count_r - CNT_W'(1));
                left_nxt    = CNT_W'(cnt_p1 - pos_x);
                state_nxt   = S_SHIFT;
              end
            end
            CMD_DELETE: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else if (!pos_ok) begin
                status_nxt = ST_BADPOS;
              end else begin
                rd_addr_nxt = ADDR_W'(in_position);
                left_nxt    = CNT_W'(cnt_x - pos_x);
                state_nxt   = S_SHIFT;
              end
            end
            CMD_LOCATE: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                rd_addr_nxt = '0;
                left_nxt    = count_r;
                state_nxt   = S_SCAN;
              end
            end
            default: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else if (!pos_ok) begin
                status_nxt = ST_BADPOS;
              end else begin
                rd_addr_nxt = ADDR_W'(in_position - POS_W'(1));
                state_nxt   = S_FETCH;
              end
            end
          endcase
        end
      end

      // read one entry a beat, write the previous one a slot up or down
      S_SHIFT: begin
        if (left_r != '0) begin
          mem_req.re    = 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = rd_addr_r;
          left_nxt      = left_r - CNT_W'(1);
          rd_addr_nxt   = (cmd_r == CMD_INSERT) ? rd_addr_r - ADDR_W'(1)
                                                : rd_addr_r + ADDR_W'(1);
        end
        if (pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = (cmd_r == CMD_INSERT) ? pend_addr_r + ADDR_W'(1)
                                                : pend_addr_r - ADDR_W'(1);
        end
        if (left_r == '0 && !pend_r) begin
          if (cmd_r == CMD_INSERT) begin
            state_nxt = S_PUT;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_DONE;
          end
        end
      end

      S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ins_addr_r;
        mem_req.wdata = val_r;
        count_nxt     = count_r + CNT_W'(1);
        state_nxt     = S_DONE;
      end

      S_SCAN: begin
        if (hit) begin
          found_nxt = CNT_W'(pend_addr_r) + CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          if (left_r != '0) begin
            mem_req.re    = 1'b1;
            pend_nxt      = 1'b1;
            pend_addr_nxt = rd_addr_r;
            left_nxt      = left_r - CNT_W'(1);
            rd_addr_nxt   = rd_addr_r + ADDR_W'(1);
          end else if (pend_r) begin
            status_nxt = ST_NOTFOUND;
            state_nxt  = S_DONE;
          end
        end
      end

      S_FETCH: begin
        mem_req.re = 1'b1;
        state_nxt  = S_GRAB;
      end

      S_GRAB: begin
        rdv_nxt   = mem_rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    val_r       <= val_nxt;
    ins_addr_r  <= ins_addr_nxt;
    rd_addr_r   <= rd_addr_nxt;
    left_r      <= left_nxt;
    pend_addr_r <= pend_addr_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
    rdv_r       <= rdv_nxt;
  end

endmodule

// File: rtl/ordered_array_list.sv
// Ordered array list, top level: sequencer, entry store and output register.
// Depends on olst_pkg, olst_store and olst_seq.
//
// Usage: commands arrive on the in_ channel (valid/ready): insert, delete,
// locate or read, with a 1-based position and a 32-bit value. Each command
// yields exactly one result beat on the out_ channel carrying status,
// found position, read value and the entry count after the command.
// A refused command goes straight to its result. Read fetches the entry from
// the store; locate scans the entries in order up to the first match. Insert
// moves the entries from the position up one slot and then writes the new
// value; delete moves the entries behind the position down one slot. The worst
// case is an insert at the head of a list of seven. The rate is set by
// the single read port of the entry store: the shift and scan loops move
// one entry a cycle.
// One command is in work at a time; in_ready is high only while idle.
// The result sits in an output register, so the next command is taken while
// a result still waits; a stalled receiver holds the result there and the
// sequencer waits with the next one until the register frees up.
// Reset empties the list (count zero); entries are not cleared.
`timescale 1ns / 1ps

module ordered_array_list (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [olst_pkg::CMD_W-1:0]          in_cmd,
  input  logic [olst_pkg::POS_W-1:0]          in_position,
  input  logic signed [olst_pkg::VAL_W-1:0]   in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [olst_pkg::STAT_W-1:0]         out_status,
  output logic [olst_pkg::CNT_W-1:0]          out_found_position,
  output logic signed [olst_pkg::VAL_W-1:0]   out_read_value,
  output logic [olst_pkg::CNT_W-1:0]          out_item_count
);
  import olst_pkg::*;

  mem_req_t         mem_req;
  logic [VAL_W-1:0] mem_rdata;
  logic             res_valid, res_ready;
  result_t          res;

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  olst_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  olst_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_position (in_position),
    .in_value    (in_value),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_found_position = out_res_r.found_position;
  assign out_read_value     = out_res_r.read_value;
  assign out_item_count     = out_res_r.item_count;

endmodule

// File: verif/olst_list_checker.sv
// Checker for the ordered array list: watches both channels, predicts each result.
// Depends on olst_pkg for sizes, command and status codes and result_t.
`timescale 1ns / 1ps

module olst_list_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [olst_pkg::CMD_W-1:0]         in_cmd,
  input  logic [olst_pkg::POS_W-1:0]         in_position,
  input  logic signed [olst_pkg::VAL_W-1:0]  in_value,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [olst_pkg::STAT_W-1:0]        out_status,
  input  logic [olst_pkg::CNT_W-1:0]         out_found_position,
  input  logic signed [olst_pkg::VAL_W-1:0]  out_read_value,
  input  logic [olst_pkg::CNT_W-1:0]         out_item_count,
  output int                                 fail_count,
  output int                                 pending_count
);
  import olst_pkg::*;

  // shadow list: entries[k] holds position k+1
  logic [VAL_W-1:0] entries [CAPACITY];
  logic [CNT_W-1:0] entry_total = '0;
  result_t          awaited_results [$];
  result_t          want;
  bit               beat_ok;

  function automatic result_t apply_command(input logic [CMD_W-1:0] cmd,
                                            input logic [POS_W-1:0] pos,
                                            input logic [VAL_W-1:0] val);
    result_t res;
    int      p;
    int      n;
    p   = int'(pos);
    n   = int'(entry_total);
    res = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        // position range is checked before the full condition
        if (p == 0 || p > n + 1) begin
          res.status = ST_BADPOS;
        end else if (n >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int k = n; k >= p; k--) entries[k] = entries[k-1];
          entries[p-1] = val;
          n++;
        end
      end
      CMD_DELETE: begin
        if (n == 0) begin
          res.status = ST_EMPTY;
        end else if (p == 0 || p > n) begin
          res.status = ST_BADPOS;
        end else begin
          for (int k = p; k < n; k++) entries[k-1] = entries[k];
          n--;
        end
      end
      CMD_LOCATE: begin
        if (n == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_NOTFOUND;
          // first match wins
          for (int k = n - 1; k >= 0; k--) begin
            if (entries[k] == val) begin
              res.status         = ST_OK;
              res.found_position = CNT_W'(k + 1);
            end
          end
        end
      end
      default: begin
        if (n == 0) begin
          res.status = ST_EMPTY;
        end else if (p == 0 || p > n) begin
          res.status = ST_BADPOS;
        end else begin
          res.read_value = entries[p-1];
        end
      end
    endcase
    entry_total    = CNT_W'(n);
    res.item_count = entry_total;
    return res;
  endfunction

  function automatic bit field_ok(input string name, input logic [VAL_W-1:0] exp_val,
                                  input logic [VAL_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h",
               $time, name, exp_val, act_val);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t ns: result beat, expected none, actual status %0d count %0d",
                   $time, out_status, out_item_count);
          fail_count++;
        end else begin
          want    = awaited_results.pop_front();
          beat_ok = 1'b1;
          if (!field_ok("status", VAL_W'(want.status), VAL_W'(out_status)))
            beat_ok = 1'b0;
          if (!field_ok("found_position", VAL_W'(want.found_position),
                        VAL_W'(out_found_position)))
            beat_ok = 1'b0;
          if (!field_ok("read_value", want.read_value, out_read_value))
            beat_ok = 1'b0;
          if (!field_ok("item_count", VAL_W'(want.item_count), VAL_W'(out_item_count)))
            beat_ok = 1'b0;
          if (!beat_ok) fail_count++;
        end
      end
      if (in_valid && in_ready)
        awaited_results.push_back(apply_command(in_cmd, in_position, in_value));
      pending_count = awaited_results.size();
    end
  end

endmodule

// File: verif/testbench.sv
// Top of the ordered array list testbench: clock, reset, command stimulus and verdict.
// Depends on olst_pkg, ordered_array_list and olst_list_checker.
`timescale 1ns / 1ps

module testbench;
  import olst_pkg::*;

  logic                    clk;
  logic                    rst_n              = 1'b0;
  logic                    in_valid           = 1'b0;
  logic                    in_ready;
  logic [CMD_W-1:0]        in_cmd             = CMD_READ;
  logic [POS_W-1:0]        in_position        = '0;
  logic signed [VAL_W-1:0] in_value           = '0;
  logic                    out_valid;
  logic                    out_ready          = 1'b0;
  logic [STAT_W-1:0]       out_status;
  logic [CNT_W-1:0]        out_found_position;
  logic signed [VAL_W-1:0] out_read_value;
  logic [CNT_W-1:0]        out_item_count;

  int fail_count;
  int pending_count;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  // stimulus-side bookkeeping: only commands known to succeed move list_fill
  int               list_fill  = 0;
  bit               grow_phase = 1'b1;
  logic [VAL_W-1:0] recent_values [8];

  ordered_array_list DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_read_value     (out_read_value),
    .out_item_count     (out_item_count)
  );

  olst_list_checker u_list_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_read_value     (out_read_value),
    .out_item_count     (out_item_count),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                          input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(3))
      0:       return VAL_W'($urandom_range(3));
      1: begin
        case ($urandom_range(3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic random_item(output logic [CMD_W-1:0] cmd, output logic [POS_W-1:0] pos,
                             output logic [VAL_W-1:0] val);
    int roll;
    int lim;
    int ins_w;
    int del_w;
    if ($urandom_range(29) == 0) grow_phase = !grow_phase;
    val = $urandom();
    if ($urandom_range(99) < 15) begin
      // malformed: positions out of range, nothing may change
      cmd = CMD_W'($urandom_range(3));
      lim = (cmd == CMD_INSERT) ? list_fill + 1 : list_fill;
      if (cmd == CMD_LOCATE)
        pos = POS_W'($urandom_range(15));
      else if (lim >= 15 || $urandom_range(1) == 0)
        pos = '0;
      else
        pos = POS_W'($urandom_range(15, lim + 1));
    end else begin
      ins_w = grow_phase ? 55 : 20;
      del_w = grow_phase ? 15 : 50;
      roll  = $urandom_range(99);
      if (roll < ins_w)
        cmd = CMD_INSERT;
      else if (roll < ins_w + del_w)
        cmd = CMD_DELETE;
      else if (roll < ins_w + del_w + (100 - ins_w - del_w) / 2)
        cmd = CMD_LOCATE;
      else
        cmd = CMD_READ;
      case (cmd)
        CMD_INSERT: begin
          val = pick_value();
          if (list_fill < CAPACITY) begin
            pos = POS_W'($urandom_range(list_fill + 1, 1));
            list_fill++;
            recent_values[$urandom_range(7)] = val;
          end else begin
            pos = POS_W'($urandom_range(CAPACITY + 1, 1));
          end
        end
        CMD_DELETE: begin
          if (list_fill > 0) begin
            pos = POS_W'($urandom_range(list_fill, 1));
            list_fill--;
          end else begin
            pos = POS_W'($urandom_range(15));
          end
        end
        CMD_LOCATE: begin
          pos = POS_W'($urandom_range(15));
          val = ($urandom_range(9) < 6) ? recent_values[$urandom_range(7)] : pick_value();
        end
        default: begin
          pos = (list_fill > 0) ? POS_W'($urandom_range(list_fill, 1))
                                : POS_W'($urandom_range(15));
        end
      endcase
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int hold,
                           input int n_items);
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    hold_left      = hold;
    @(posedge clk);
    repeat (n_items) begin
      random_item(cmd, pos, val);
      send_cmd(cmd, pos, val);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    foreach (recent_values[i]) recent_values[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list
    send_cmd(CMD_READ,   4'd1,  32'h0);
    send_cmd(CMD_DELETE, 4'd1,  32'h0);
    send_cmd(CMD_LOCATE, 4'd0,  32'h0);
    send_cmd(CMD_INSERT, 4'd0,  32'h1);
    send_cmd(CMD_INSERT, 4'd2,  32'h1);
    // fill to capacity from both ends and the middle, with a duplicate
    send_cmd(CMD_INSERT, 4'd1,  32'h8000_0000);
    send_cmd(CMD_INSERT, 4'd2,  32'h7FFF_FFFF);
    send_cmd(CMD_INSERT, 4'd1,  32'h0000_0000);
    send_cmd(CMD_INSERT, 4'd4,  32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 4'd2,  32'hAAAA_AAAA);
    send_cmd(CMD_INSERT, 4'd3,  32'h5555_5555);
    send_cmd(CMD_INSERT, 4'd7,  32'h1234_5678);
    send_cmd(CMD_INSERT, 4'd5,  32'h7FFF_FFFF);
    // full list: valid position gives full, far position gives bad position
    send_cmd(CMD_INSERT, 4'd9,  32'h1);
    send_cmd(CMD_INSERT, 4'd15, 32'h1);
    send_cmd(CMD_READ,   4'd0,  32'h0);
    send_cmd(CMD_READ,   4'd8,  32'h0);
    send_cmd(CMD_READ,   4'd9,  32'h0);
    send_cmd(CMD_LOCATE, 4'd0,  32'h7FFF_FFFF);
    send_cmd(CMD_LOCATE, 4'd0,  32'h0000_0001);
    send_cmd(CMD_DELETE, 4'd0,  32'h0);
    send_cmd(CMD_DELETE, 4'd9,  32'h0);
    send_cmd(CMD_DELETE, 4'd8,  32'h0);
    send_cmd(CMD_DELETE, 4'd1,  32'h0);
    send_cmd(CMD_READ,   4'd15, 32'h0);
    in_valid <= 1'b0;
    list_fill = 6;

    run_phase(0,  0,  0,   220);
    run_phase(50, 0,  0,   220);
    run_phase(0,  50, 0,   220);
    run_phase(34, 34, 0,   220);
    // receiver held off while commands keep coming, so the block backs up
    run_phase(0,  0,  400, 200);

    @(posedge clk);
    wait (pending_count == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
